/* rtl/mae_pkg.sv */
// Package for the misaligned access emulator: word types, codes, decode table.
// No dependencies.
`default_nettype none
package mae_pkg;

    localparam int MaxAccessBytes = 8;

    typedef enum logic [1:0] {
        OP_TRAP  = 2'd0,
        OP_BYTE  = 2'd1,
        OP_REGV  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_READ   = 3'd0,
        K_WRITE  = 3'd1,
        K_RREAD  = 3'd2,
        K_RWRITE = 3'd3,
        K_DONE   = 3'd4,
        K_REDIR  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LREQ,
        ST_LWAIT,
        ST_LWR,
        ST_SWAIT,
        ST_SWR,
        ST_DONE,
        ST_ONE
    } state_t;

    typedef enum logic [1:0] {
        CFG_XLEN = 2'd0,
        CFG_FP   = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] instruction_word;
        logic [63:0] fault_address;
        logic [7:0]  data_byte;
        logic [63:0] register_value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] mem_address;
        logic [7:0]  mem_byte;
        logic [4:0]  reg_index;
        logic        reg_is_fp;
        logic [63:0] reg_value;
        logic [2:0]  pc_advance;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic       hit;
        logic       load;
        logic       fp;
        logic       sign;
        logic [3:0] width;
        logic [4:0] reg_num;
        logic [2:0] size;
    } dec_t;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic collect;
        logic take_val;
        logic step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       bytes_full;
        logic       idx_last;
    } stat_t;

    function automatic dec_t decode(logic [31:0] insn, logic x64, logic [1:0] fps);
        dec_t       d;
        logic [31:0] w;
        logic [2:0] f3;
        logic [6:0] opc;
        logic       fp_ok;
        d = '0;
        opc = '0;
        if (insn[1:0] != 2'b11) begin
            w = {16'd0, insn[15:0]};
            d.size = 3'd2;
            f3 = w[15:13];
            d.hit = 1'b1;
            unique case ({w[1:0], f3})
                {2'b00, 3'd1}: begin d.fp = 1'b1; d.load = 1'b1; d.width = 4'd8; end
                {2'b00, 3'd2}: begin d.load = 1'b1; d.width = 4'd4; d.sign = 1'b1; end
                {2'b00, 3'd3}: begin
                    if (x64) begin d.load = 1'b1; d.width = 4'd8; d.sign = 1'b1; end
                    else begin d.fp = 1'b1; d.load = 1'b1; d.width = 4'd4; end
                end
                {2'b00, 3'd5}: begin d.fp = 1'b1; d.width = 4'd8; end
                {2'b00, 3'd6}: d.width = 4'd4;
                {2'b00, 3'd7}: begin
                    d.width = x64 ? 4'd8 : 4'd4;
                    d.fp = !x64;
                end
                {2'b10, 3'd1}: begin d.fp = 1'b1; d.load = 1'b1; d.width = 4'd8; end
                {2'b10, 3'd2}: begin d.load = 1'b1; d.width = 4'd4; d.sign = 1'b1; end
                {2'b10, 3'd3}: begin
                    if (x64) begin d.load = 1'b1; d.width = 4'd8; d.sign = 1'b1; end
                    else begin d.fp = 1'b1; d.load = 1'b1; d.width = 4'd4; end
                end
                {2'b10, 3'd5}: begin d.fp = 1'b1; d.width = 4'd8; end
                {2'b10, 3'd6}: d.width = 4'd4;
                {2'b10, 3'd7}: begin
                    d.width = x64 ? 4'd8 : 4'd4;
                    d.fp = !x64;
                end
                default: d.hit = 1'b0;
            endcase
            if (w[1:0] == 2'b00)
                d.reg_num = {2'b01, w[4:2]};
            else if (d.load)
                d.reg_num = w[11:7];
            else
                d.reg_num = w[6:2];
        end else begin
            w = insn;
            d.size = 3'd4;
            f3 = w[14:12];
            opc = w[6:0];
            d.hit = 1'b1;
            unique case ({opc, f3})
                {7'h03, 3'd0}: begin d.load = 1'b1; d.width = 4'd1; d.sign = 1'b1; end
                {7'h03, 3'd1}: begin d.load = 1'b1; d.width = 4'd2; d.sign = 1'b1; end
                {7'h03, 3'd2}: begin d.load = 1'b1; d.width = 4'd4; d.sign = 1'b1; end
                {7'h03, 3'd3}: begin
                    d.load = 1'b1; d.width = 4'd8; d.sign = 1'b1; d.hit = x64;
                end
                {7'h03, 3'd4}: begin d.load = 1'b1; d.width = 4'd1; end
                {7'h03, 3'd5}: begin d.load = 1'b1; d.width = 4'd2; end
                {7'h03, 3'd6}: begin d.load = 1'b1; d.width = 4'd4; d.hit = x64; end
                {7'h23, 3'd0}: d.width = 4'd1;
                {7'h23, 3'd1}: d.width = 4'd2;
                {7'h23, 3'd2}: d.width = 4'd4;
                {7'h23, 3'd3}: begin d.width = 4'd8; d.hit = x64; end
                {7'h07, 3'd2}: begin d.fp = 1'b1; d.load = 1'b1; d.width = 4'd4; end
                {7'h07, 3'd3}: begin d.fp = 1'b1; d.load = 1'b1; d.width = 4'd8; end
                {7'h27, 3'd2}: begin d.fp = 1'b1; d.width = 4'd4; end
                {7'h27, 3'd3}: begin d.fp = 1'b1; d.width = 4'd8; end
                default: d.hit = 1'b0;
            endcase
            d.reg_num = d.load ? w[11:7] : w[24:20];
            if (insn[4:2] == 3'd7)
                d.hit = 1'b0;
        end
        fp_ok = (d.width == 4'd4 && fps != 2'd0) || (d.width == 4'd8 && fps[1]);
        if (d.fp && !fp_ok)
            d.hit = 1'b0;
        if (d.width > 4'(MaxAccessBytes))
            d.hit = 1'b0;
        return d;
    endfunction

endpackage
`default_nettype wire

/* rtl/mae_datapath.sv */
// Datapath: access registers, byte collection, sign extension, result word build.
// Depends on mae_pkg.
`default_nettype none
module mae_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mae_pkg::in_word_t in_w,
    input  wire logic              xlen_is_64,
    input  wire logic [1:0]        fp_support,
    input  wire mae_pkg::cmd_t     cmd,
    input  wire mae_pkg::state_t   st,
    output mae_pkg::stat_t         stat,
    output mae_pkg::dec_t          dec,
    output mae_pkg::out_word_t     res
);
    logic [3:0]  width_reg;
    logic [4:0]  reg_num_reg;
    logic        fp_reg, sign_reg;
    logic [63:0] buf_reg, buf_next;
    logic [3:0]  cnt_reg;
    logic [2:0]  size_reg;
    logic [63:0] base_reg;
    logic [3:0]  idx_reg;
    logic [63:0] lval, sval;
    logic        sbit;

    assign dec = mae_pkg::decode(in_w.instruction_word, xlen_is_64, fp_support);

    always_comb
    begin
        buf_next = buf_reg;
        buf_next[{cnt_reg[2:0], 3'b000} +: 8] = in_w.data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else
            begin
                if (cmd.collect && cnt_reg < width_reg)
                    cnt_reg <= cnt_reg + 4'd1;
                if (cmd.step)
                    idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            width_reg   <= dec.width;
            reg_num_reg <= dec.reg_num;
            fp_reg      <= dec.fp;
            sign_reg    <= dec.sign;
            size_reg    <= dec.size;
            base_reg    <= in_w.fault_address;
            buf_reg     <= '0;
        end
        else if (cmd.collect && cnt_reg < width_reg)
            buf_reg <= buf_next;
        else if (cmd.take_val)
            buf_reg <= (!fp_reg && !xlen_is_64) ? {32'd0, in_w.register_value[31:0]}
                                                 : in_w.register_value;
    end

    always_comb
    begin
        sbit = buf_reg[{width_reg[2:0] - 3'd1, 3'b111}];
        lval = buf_reg;
        if (sign_reg && !width_reg[3] && sbit)
            lval = buf_reg | (~64'd0 << {width_reg[2:0], 3'b000});
        if (!fp_reg && !xlen_is_64)
            lval[63:32] = '0;
        sval = buf_reg >> {idx_reg[2:0], 3'b000};
    end

    assign stat.bytes_full = (cnt_reg + 4'd1 >= width_reg);
    assign stat.idx_last   = (idx_reg + 4'd1 == width_reg);

    always_comb
    begin
        res = '0;
        unique case (st)
            mae_pkg::ST_LREQ:
            begin
                res.kind        = mae_pkg::K_READ;
                res.mem_address = base_reg + {60'd0, idx_reg};
                res.last        = stat.idx_last;
            end
            mae_pkg::ST_LWR:
            begin
                res.kind      = mae_pkg::K_RWRITE;
                res.reg_index = reg_num_reg;
                res.reg_is_fp = fp_reg;
                res.reg_value = lval;
            end
            mae_pkg::ST_SWR:
            begin
                res.kind        = mae_pkg::K_WRITE;
                res.mem_address = base_reg + {60'd0, idx_reg};
                res.mem_byte    = sval[7:0];
            end
            mae_pkg::ST_DONE:
            begin
                res.kind       = mae_pkg::K_DONE;
                res.pc_advance = size_reg;
                res.last       = 1'b1;
            end
            mae_pkg::ST_ONE:
            begin
                res.kind      = mae_pkg::K_RREAD;
                res.reg_index = reg_num_reg;
                res.reg_is_fp = fp_reg;
                res.last      = 1'b1;
            end
            default: res = '0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/mae_ctrl.sv */
// Controller state machine: sequences request, collect and write words.
// Depends on mae_pkg.
`default_nettype none
module mae_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        op,
    input  wire mae_pkg::dec_t     dec,
    input  wire mae_pkg::stat_t    stat,
    output mae_pkg::cmd_t          cmd,
    output mae_pkg::state_t        st,
    output logic                   redir,
    output logic                   out_valid,
    input  wire logic              out_ready
);
    mae_pkg::state_t state_reg, state_next;
    logic redir_reg, redir_next;
    logic acc, fire;

    assign st    = state_reg;
    assign redir = redir_reg;
    assign acc   = in_valid && in_ready;
    assign fire  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mae_pkg::ST_IDLE;
            redir_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            redir_reg <= redir_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        redir_next = redir_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            mae_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                if (acc && op == mae_pkg::OP_TRAP)
                begin
                    cmd.start = dec.hit;
                    redir_next = !dec.hit;
                    if (!dec.hit)
                        state_next = mae_pkg::ST_ONE;
                    else if (dec.load)
                        state_next = mae_pkg::ST_LREQ;
                    else
                        state_next = mae_pkg::ST_ONE;
                end
            end
            mae_pkg::ST_LREQ:
            begin
                out_valid = 1'b1;
                if (fire)
                begin
                    cmd.step = 1'b1;
                    if (stat.idx_last)
                        state_next = mae_pkg::ST_LWAIT;
                end
            end
            mae_pkg::ST_LWAIT:
            begin
                in_ready = 1'b1;
                if (acc && op == mae_pkg::OP_TRAP)
                begin
                    cmd.start  = dec.hit;
                    redir_next = !dec.hit;
                    state_next = (dec.hit && dec.load) ? mae_pkg::ST_LREQ : mae_pkg::ST_ONE;
                end
                else if (acc && op == mae_pkg::OP_BYTE)
                begin
                    cmd.collect = 1'b1;
                    if (stat.bytes_full)
                        state_next = mae_pkg::ST_LWR;
                end
            end
            mae_pkg::ST_LWR:
            begin
                out_valid = 1'b1;
                if (fire)
                    state_next = mae_pkg::ST_DONE;
            end
            mae_pkg::ST_SWAIT:
            begin
                in_ready = 1'b1;
                if (acc && op == mae_pkg::OP_TRAP)
                begin
                    cmd.start  = dec.hit;
                    redir_next = !dec.hit;
                    state_next = (dec.hit && dec.load) ? mae_pkg::ST_LREQ : mae_pkg::ST_ONE;
                end
                else if (acc && op == mae_pkg::OP_REGV)
                begin
                    cmd.take_val = 1'b1;
                    state_next   = mae_pkg::ST_SWR;
                end
            end
            mae_pkg::ST_SWR:
            begin
                out_valid = 1'b1;
                if (fire)
                begin
                    cmd.step = 1'b1;
                    if (stat.idx_last)
                        state_next = mae_pkg::ST_DONE;
                end
            end
            mae_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (fire)
                    state_next = mae_pkg::ST_IDLE;
            end
            mae_pkg::ST_ONE:
            begin
                out_valid = 1'b1;
                if (fire)
                begin
                    state_next = redir_reg ? mae_pkg::ST_IDLE : mae_pkg::ST_SWAIT;
                    redir_next = 1'b0;
                end
            end
            default: state_next = mae_pkg::ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output handshakes overlap");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.collect, cmd.take_val, cmd.step}))
        else $error("more than one datapath command");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.collect |=> (state_reg == mae_pkg::ST_LWAIT || state_reg == mae_pkg::ST_LWR))
        else $error("byte collect left load wait");
endmodule
`default_nettype wire

/* rtl/misaligned_access_emulator.sv */
// Top level of the misaligned access emulator: config registers, controller, datapath.
// Depends on mae_pkg, mae_ctrl, mae_datapath.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    mae_pkg::in_word_t
// out      output     out_valid / out_ready  mae_pkg::out_word_t
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input word at a time; results follow one per cycle while out_ready is high.
// A load of N bytes gives N read words, then after the N byte words a write-back
// and a complete; a store gives a register read, then after the value word N
// write words and a complete; a redirect is a single word.
// The sequencer state machine sets these counts. Reset clears all control state.
// Output stalls hold the sequencer; input is taken only while no word is pending.
`default_nettype none
module misaligned_access_emulator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mae_pkg::in_word_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mae_pkg::out_word_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [1:0]         cfg_data
);
    logic             xlen_reg;
    logic [1:0]       fps_reg;
    mae_pkg::cmd_t    cmd;
    mae_pkg::stat_t   stat;
    mae_pkg::dec_t    dec;
    mae_pkg::state_t  st;
    mae_pkg::out_word_t res;
    logic             redir;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xlen_reg <= 1'b1;
            fps_reg  <= 2'd2;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == mae_pkg::CFG_XLEN)
                xlen_reg <= cfg_data[0];
            else if (cfg_index == mae_pkg::CFG_FP)
                fps_reg <= cfg_data;
        end
    end

    mae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (in_data.op),
        .dec       (dec),
        .stat      (stat),
        .cmd       (cmd),
        .st        (st),
        .redir     (redir),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    mae_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_w       (in_data),
        .xlen_is_64 (xlen_reg),
        .fp_support (fps_reg),
        .cmd        (cmd),
        .st         (st),
        .stat       (stat),
        .dec        (dec),
        .res        (res)
    );

    always_comb
    begin
        out_data = res;
        if (st == mae_pkg::ST_ONE && redir)
        begin
            out_data      = '0;
            out_data.kind = mae_pkg::K_REDIR;
            out_data.last = 1'b1;
        end
    end
endmodule
`default_nettype wire

/* verif/mae_checker.sv */
// Checker for the misaligned access emulator: watches the three channels, predicts result words.
// Depends on mae_pkg.
`timescale 1ns / 100ps
module mae_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire mae_pkg::in_word_t  in_data,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire mae_pkg::out_word_t out_data,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [1:0]         cfg_data,
    output int                      fail_count,
    output int                      pending,
    output int                      words_checked
);
    typedef enum logic [1:0] {ANY_XLEN, ONLY_RV32, ONLY_RV64} xlen_sel_t;
    typedef enum logic [1:0] {EMU_IDLE, EMU_LOAD, EMU_STORE} emu_phase_t;

    typedef struct {
        logic [31:0] code;
        logic [31:0] mask;
        int          shift;
        logic [4:0]  rmask;
        logic [4:0]  radd;
        logic        fp;
        logic        ld;
        logic [3:0]  width;
        logic        sgn;
        xlen_sel_t   sel;
    } pattern_row_t;

    pattern_row_t       decode_rows[$];
    mae_pkg::out_word_t expected_words[$];

    logic        x64;
    logic [1:0]  fp_level;
    emu_phase_t  emu_phase;
    logic [3:0]  acc_width;
    logic [4:0]  acc_reg;
    logic        acc_fp;
    logic        acc_sign;
    logic [63:0] gathered;
    logic [3:0]  gathered_cnt;
    logic [2:0]  instr_len;
    logic [63:0] acc_base;

    function automatic pattern_row_t row(logic [31:0] code, logic [31:0] mask, int shift,
                                         logic [4:0] rmask, logic [4:0] radd, logic fp,
                                         logic ld, logic [3:0] width, logic sgn,
                                         xlen_sel_t sel);
        pattern_row_t r;
        r = '{code, mask, shift, rmask, radd, fp, ld, width, sgn, sel};
        return r;
    endfunction

    initial
    begin
        decode_rows = '{
            row(32'h2000, 32'he003,  2,  7, 8, 1, 1, 8, 0, ANY_XLEN),
            row(32'h4000, 32'he003,  2,  7, 8, 0, 1, 4, 1, ANY_XLEN),
            row(32'h6000, 32'he003,  2,  7, 8, 1, 1, 4, 0, ONLY_RV32),
            row(32'h6000, 32'he003,  2,  7, 8, 0, 1, 8, 1, ONLY_RV64),
            row(32'ha000, 32'he003,  2,  7, 8, 1, 0, 8, 0, ANY_XLEN),
            row(32'hc000, 32'he003,  2,  7, 8, 0, 0, 4, 0, ANY_XLEN),
            row(32'he000, 32'he003,  2,  7, 8, 1, 0, 4, 0, ONLY_RV32),
            row(32'he000, 32'he003,  2,  7, 8, 0, 0, 8, 0, ONLY_RV64),
            row(32'h2002, 32'he003,  7, 31, 0, 1, 1, 8, 0, ANY_XLEN),
            row(32'h4002, 32'he003,  7, 31, 0, 0, 1, 4, 1, ANY_XLEN),
            row(32'h6002, 32'he003,  7, 31, 0, 1, 1, 4, 0, ONLY_RV32),
            row(32'h6002, 32'he003,  7, 31, 0, 0, 1, 8, 1, ONLY_RV64),
            row(32'ha002, 32'he003,  2, 31, 0, 1, 0, 8, 0, ANY_XLEN),
            row(32'hc002, 32'he003,  2, 31, 0, 0, 0, 4, 0, ANY_XLEN),
            row(32'he002, 32'he003,  2, 31, 0, 1, 0, 4, 0, ONLY_RV32),
            row(32'he002, 32'he003,  2, 31, 0, 0, 0, 8, 0, ONLY_RV64),
            row(32'h0003, 32'h707f,  7, 31, 0, 0, 1, 1, 1, ANY_XLEN),
            row(32'h1003, 32'h707f,  7, 31, 0, 0, 1, 2, 1, ANY_XLEN),
            row(32'h2003, 32'h707f,  7, 31, 0, 0, 1, 4, 1, ANY_XLEN),
            row(32'h3003, 32'h707f,  7, 31, 0, 0, 1, 8, 1, ONLY_RV64),
            row(32'h4003, 32'h707f,  7, 31, 0, 0, 1, 1, 0, ANY_XLEN),
            row(32'h5003, 32'h707f,  7, 31, 0, 0, 1, 2, 0, ANY_XLEN),
            row(32'h6003, 32'h707f,  7, 31, 0, 0, 1, 4, 0, ONLY_RV64),
            row(32'h0023, 32'h707f, 20, 31, 0, 0, 0, 1, 0, ANY_XLEN),
            row(32'h1023, 32'h707f, 20, 31, 0, 0, 0, 2, 0, ANY_XLEN),
            row(32'h2023, 32'h707f, 20, 31, 0, 0, 0, 4, 0, ANY_XLEN),
            row(32'h3023, 32'h707f, 20, 31, 0, 0, 0, 8, 0, ONLY_RV64),
            row(32'h2007, 32'h707f,  7, 31, 0, 1, 1, 4, 0, ANY_XLEN),
            row(32'h3007, 32'h707f,  7, 31, 0, 1, 1, 8, 0, ANY_XLEN),
            row(32'h2027, 32'h707f, 20, 31, 0, 1, 0, 4, 0, ANY_XLEN),
            row(32'h3027, 32'h707f, 20, 31, 0, 1, 0, 8, 0, ANY_XLEN)
        };
    end

    function automatic mae_pkg::out_word_t mk(mae_pkg::kind_t kind, logic [63:0] addr,
                                              logic [7:0] b, logic [4:0] ri, logic fp,
                                              logic [63:0] val, logic [2:0] adv,
                                              logic last);
        mae_pkg::out_word_t w;
        w.kind = kind;
        w.mem_address = addr;
        w.mem_byte = b;
        w.reg_index = ri;
        w.reg_is_fp = fp;
        w.reg_value = val;
        w.pc_advance = adv;
        w.last = last;
        return w;
    endfunction

    task automatic push_redirect();
        emu_phase = EMU_IDLE;
        expected_words.push_back(mk(mae_pkg::K_REDIR, 0, 0, 0, 0, 0, 0, 1));
    endtask

    task automatic begin_trap(logic [31:0] insn, logic [63:0] addr);
        int          hit;
        logic [2:0]  size;
        logic [1:0]  fps;
        pattern_row_t m;
        hit = -1;
        emu_phase = EMU_IDLE;
        if (insn[1:0] != 2'b11)
        begin
            insn = {16'd0, insn[15:0]};
            size = 3'd2;
        end
        else if (insn[4:2] != 3'd7)
            size = 3'd4;
        else
        begin
            push_redirect();
            return;
        end
        foreach (decode_rows[i])
        begin
            if (hit < 0 && !(decode_rows[i].sel == ONLY_RV32 && x64)
                && !(decode_rows[i].sel == ONLY_RV64 && !x64)
                && (insn & decode_rows[i].mask) == decode_rows[i].code)
                hit = i;
        end
        if (hit < 0)
        begin
            push_redirect();
            return;
        end
        m = decode_rows[hit];
        fps = fp_level > 2 ? 2'd2 : fp_level;
        if (m.fp && !((m.width == 4 && fps >= 1) || (m.width == 8 && fps >= 2)))
        begin
            push_redirect();
            return;
        end
        acc_width = m.width;
        acc_reg = 5'(((insn >> m.shift) & 32'(m.rmask)) + 32'(m.radd));
        acc_fp = m.fp;
        acc_sign = m.sgn;
        gathered = '0;
        gathered_cnt = '0;
        instr_len = size;
        acc_base = addr;
        if (m.ld)
        begin
            emu_phase = EMU_LOAD;
            for (int i = 0; i < acc_width; i++)
                expected_words.push_back(mk(mae_pkg::K_READ, addr + i, 0, 0, 0, 0, 0,
                                            i + 1 == acc_width));
        end
        else
        begin
            emu_phase = EMU_STORE;
            expected_words.push_back(mk(mae_pkg::K_RREAD, 0, 0, acc_reg, acc_fp, 0, 0, 1));
        end
    endtask

    task automatic predict(mae_pkg::in_word_t w);
        logic [63:0] v;
        if (w.op == mae_pkg::OP_TRAP)
            begin_trap(w.instruction_word, w.fault_address);
        else if (w.op == mae_pkg::OP_BYTE && emu_phase == EMU_LOAD)
        begin
            if (gathered_cnt < acc_width)
            begin
                gathered |= 64'(w.data_byte) << (8 * gathered_cnt);
                gathered_cnt++;
            end
            if (gathered_cnt >= acc_width)
            begin
                v = gathered;
                if (acc_sign && acc_width < 8 && v[8 * acc_width - 1])
                    v |= ~64'd0 << (8 * acc_width);
                if (!acc_fp && !x64)
                    v &= 64'hffff_ffff;
                emu_phase = EMU_IDLE;
                expected_words.push_back(mk(mae_pkg::K_RWRITE, 0, 0, acc_reg, acc_fp, v,
                                            0, 0));
                expected_words.push_back(mk(mae_pkg::K_DONE, 0, 0, 0, 0, 0, instr_len, 1));
            end
        end
        else if (w.op == mae_pkg::OP_REGV && emu_phase == EMU_STORE)
        begin
            v = w.register_value;
            if (!acc_fp && !x64)
                v &= 64'hffff_ffff;
            for (int i = 0; i < acc_width; i++)
                expected_words.push_back(mk(mae_pkg::K_WRITE, acc_base + i, v[8 * i +: 8],
                                            0, 0, 0, 0, 0));
            emu_phase = EMU_IDLE;
            expected_words.push_back(mk(mae_pkg::K_DONE, 0, 0, 0, 0, 0, instr_len, 1));
        end
    endtask

    task automatic compare(mae_pkg::out_word_t got);
        mae_pkg::out_word_t want;
        if (expected_words.size() == 0)
        begin
            $error("unexpected result word %h", got);
            fail_count++;
            return;
        end
        want = expected_words.pop_front();
        if (got.kind !== want.kind)
            begin $error("kind exp %0d got %0d", want.kind, got.kind); fail_count++; end
        if (got.mem_address !== want.mem_address)
            begin $error("mem_address exp %h got %h", want.mem_address, got.mem_address);
                  fail_count++; end
        if (got.mem_byte !== want.mem_byte)
            begin $error("mem_byte exp %h got %h", want.mem_byte, got.mem_byte);
                  fail_count++; end
        if (got.reg_index !== want.reg_index)
            begin $error("reg_index exp %0d got %0d", want.reg_index, got.reg_index);
                  fail_count++; end
        if (got.reg_is_fp !== want.reg_is_fp)
            begin $error("reg_is_fp exp %0d got %0d", want.reg_is_fp, got.reg_is_fp);
                  fail_count++; end
        if (got.reg_value !== want.reg_value)
            begin $error("reg_value exp %h got %h", want.reg_value, got.reg_value);
                  fail_count++; end
        if (got.pc_advance !== want.pc_advance)
            begin $error("pc_advance exp %0d got %0d", want.pc_advance, got.pc_advance);
                  fail_count++; end
        if (got.last !== want.last)
            begin $error("last exp %0d got %0d", want.last, got.last); fail_count++; end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x64 = 1'b1;
            fp_level = 2'd2;
            emu_phase = EMU_IDLE;
            acc_width = '0;
            acc_reg = '0;
            acc_fp = 1'b0;
            acc_sign = 1'b0;
            gathered = '0;
            gathered_cnt = '0;
            instr_len = '0;
            acc_base = '0;
            expected_words.delete();
            fail_count = 0;
            words_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                compare(out_data);
                words_checked++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mae_pkg::CFG_XLEN)
                    x64 = cfg_data[0];
                else if (cfg_index == mae_pkg::CFG_FP)
                    fp_level = cfg_data;
            end
            if (in_valid && in_ready)
                predict(in_data);
        end
        pending = expected_words.size();
    end

endmodule

/* verif/tb_top.sv */
// Top of the misaligned access emulator testbench: clock, reset, stimulus and verdict.
// Depends on mae_pkg, misaligned_access_emulator and mae_checker.
`timescale 1ns / 100ps
module tb_top;

    localparam int IdleLimit = 600;
    localparam int DrainCycles = 30;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    mae_pkg::in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    mae_pkg::out_word_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0] cfg_index;
    logic [1:0] cfg_data;
    int        fail_count;
    int        pending;
    int        words_checked;
    int        traps_sent;
    int        idle_cycles;
    bit        no_gaps;

    localparam logic [31:0] AccessCodes [31] = '{
        32'h2000, 32'h4000, 32'h6000, 32'ha000, 32'hc000, 32'he000,
        32'h2002, 32'h4002, 32'h6002, 32'ha002, 32'hc002, 32'he002,
        32'h0003, 32'h1003, 32'h2003, 32'h3003, 32'h4003, 32'h5003, 32'h6003,
        32'h0023, 32'h1023, 32'h2023, 32'h3023,
        32'h2007, 32'h3007, 32'h2027, 32'h3027,
        32'h0001, 32'h8000, 32'h7003, 32'h001f
    };

    misaligned_access_emulator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mae_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else if (rst_n && ++idle_cycles >= IdleLimit)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 3);
            if (n != 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
        end
    end

    task automatic send_word(logic [1:0] op, logic [31:0] insn, logic [63:0] addr,
                             logic [7:0] b, logic [63:0] regv);
        int gap;
        mae_pkg::in_word_t w;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        w.op = op;
        w.instruction_word = insn;
        w.fault_address = addr;
        w.data_byte = b;
        w.register_value = regv;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        if (op == mae_pkg::OP_TRAP)
            traps_sent++;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic write_reg(mae_pkg::cfg_idx_t idx, logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_addr();
        case ($urandom_range(0, 3))
            0: return ~64'd0 - $urandom_range(0, 7);
            1: return 64'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] rand_insn();
        logic [31:0] code;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        code = AccessCodes[$urandom_range(0, 30)];
        if (code[1:0] == 2'b11)
            return code | ($urandom & ~32'h707f);
        return code | ($urandom & ~32'he003);
    endfunction

    // trap, then the load bytes and the store value in either order; broken ones stop short
    task automatic access(logic [31:0] insn, logic [63:0] addr, int nbytes, bit regv_first);
        send_word(mae_pkg::OP_TRAP, insn, addr, $urandom, {$urandom, $urandom});
        if (regv_first)
            send_word(mae_pkg::OP_REGV, $urandom, {$urandom, $urandom}, $urandom,
                      {$urandom, $urandom});
        for (int i = 0; i < nbytes; i++)
            send_word(mae_pkg::OP_BYTE, $urandom, {$urandom, $urandom}, $urandom,
                      {$urandom, $urandom});
        if (!regv_first)
            send_word(mae_pkg::OP_REGV, $urandom, {$urandom, $urandom}, $urandom,
                      {$urandom, $urandom});
    endtask

    initial
    begin
        logic [1:0] xl_set [7];
        logic [1:0] fp_set [7];
        int nb;
        xl_set = '{1, 0, 0, 1, 1, 0, 1};
        fp_set = '{2, 0, 1, 1, 3, 2, 0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = mae_pkg::CFG_XLEN;
        cfg_data = '0;
        no_gaps = 1'b0;
        traps_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: loads and stores at the extremes
        access(32'h0000_4000, ~64'd0, 8, 0);
        send_word(mae_pkg::OP_TRAP, 32'hfff0_0003, 64'h1, 0, 0);
        send_word(mae_pkg::OP_BYTE, 0, 0, 8'h80, 0);
        send_word(mae_pkg::OP_TRAP, 32'hffff_f003 & ~32'h707f | 32'h6003, 64'h3, 0, 0);
        send_word(mae_pkg::OP_TRAP, 32'h0000_3023 | 32'hfff0_0f80, ~64'd0 - 3, 0, 0);
        send_word(mae_pkg::OP_REGV, 0, 0, 0, ~64'd0);
        send_word(mae_pkg::OP_NONE, ~32'd0, ~64'd0, 8'hff, ~64'd0);
        send_word(mae_pkg::OP_BYTE, 0, 0, 8'h55, 0);
        send_word(mae_pkg::OP_TRAP, 32'h0000_001f, 64'h5, 0, 0);
        send_word(mae_pkg::OP_TRAP, 32'h0000_a002, 64'h7, 0, 0);
        send_word(mae_pkg::OP_REGV, 0, 0, 0, 64'h8000_0000_0000_0001);
        drain();

        for (int phase_i = 0; phase_i < 7; phase_i++)
        begin
            write_reg(mae_pkg::CFG_XLEN, xl_set[phase_i]);
            write_reg(mae_pkg::CFG_FP, fp_set[phase_i]);
            no_gaps = (phase_i == 3);
            for (int k = 0; k < 4; k++)
            begin
                nb = $urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : 8;
                if ($urandom_range(0, 9) == 0)
                    send_word(2'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
                              $urandom, {$urandom, $urandom});
                access(rand_insn(), rand_addr(), nb, $urandom_range(0, 1));
            end
            drain();
        end

        $display("tb_top: %0d traps over 8 register settings, %0d result words checked",
                 traps_sent, words_checked);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/mae_pkg.sv
rtl/mae_datapath.sv
rtl/mae_ctrl.sv
rtl/misaligned_access_emulator.sv
verif/mae_checker.sv
verif/tb_top.sv
